FILE: sv/kbsd_pkg.sv
// kbsd_pkg: shared types, constants and the 4-bit generator step used by the
// keyed byte substitution descrambler; no dependencies
package kbsd_pkg;

  localparam int unsigned KeyW  = 56;
  localparam int unsigned ByteW = 8;

  localparam logic [7:0] STRIDE   = 8'h11;
  localparam logic [7:0] BYTE_MIN = 8'h00;
  localparam logic [7:0] BYTE_MAX = 8'hFF;
  localparam logic [3:0] ADD_MASK = 4'hE;
  localparam logic [3:0] NIB_MASK = 4'hF;
  localparam logic [3:0] MUL_BASE = 4'd5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_GEN,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } build_state_t;

  // write request into the substitution memory
  typedef struct packed {
    logic       we;
    logic [7:0] addr;
    logic [7:0] data;
  } sub_wr_t;

  // one step x = (x*mul + add) & 0xF, mul and add derived from the seed byte
  function automatic logic [3:0] lcg_step(input logic [3:0] x, input logic [7:0] seed);
    logic [3:0] mul;
    logic [3:0] add;
    logic [7:0] prod;
    mul  = {seed[0], 3'b000} | MUL_BASE;
    add  = (seed[3:0] & ADD_MASK) | 4'd1;
    prod = x * mul;
    return (prod[3:0] + add) & NIB_MASK;
  endfunction

endpackage

FILE: sv/keyed_byte_substitution_descrambler.sv
// keyed_byte_substitution_descrambler: top level, key register, stream
// handshake and output staging; depends on kbsd_pkg, kbsd_table_build, kbsd_sub_mem
//
// usage:
//   cfg_wr_en / cfg_wr_data write the 56-bit key (bits above 55 do not exist
//   on the port); each write starts a full rebuild of the substitution table
//   in_* carries scrambled bytes, out_* the substituted bytes, one per request
//   table build: key decrement, then generating the 256-entry nibble grid, then
//   256 grid reads with stride 0x11 and a drain step; in_tready stays low for
//   the whole build after reset and after every key write
//   once built, one request per cycle is taken unless out_* stalls; the table
//   memory's read port sets that rate, and a result appears on out_* in the cycle after its request
//   reset: key clears to zero (which acts as all ones after the decrement) and
//   the build starts right after reset release
//   stall: the memory read register doubles as the output register; while
//   out_tready is low it holds; after the build, in_tready drops only when a result waits
//   and out_tready is low, so a full stream moves with no bubbles
//   entries 0 and 255 are pinned at the output mux rather than stored
module keyed_byte_substitution_descrambler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [55:0] cfg_wr_data,  // cipher_key
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] cipher_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata     // [7:0] plain_byte
);
  import kbsd_pkg::*;

  logic [KeyW-1:0] key_r;
  logic            tbl_ready;
  sub_wr_t         sub_wr;
  logic            in_acc;
  logic [7:0]      rd_data;
  logic            out_vld_r;
  logic            pin_lo_r, pin_hi_r;

  // key register, reset value zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr_en) begin
      key_r <= cfg_wr_data;
    end
  end

  kbsd_table_build u_build (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_wr_en),
    .key    (key_r),
    .sub_wr (sub_wr),
    .ready  (tbl_ready)
  );

  // lookups only once the build is done, so reads never meet table writes
  assign in_tready = tbl_ready && (!out_vld_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  kbsd_sub_mem u_mem (
    .clk     (clk),
    .wr      (sub_wr),
    .rd_en   (in_acc),
    .rd_addr (in_tdata),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // pinned entries travel beside the memory read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pin_lo_r <= (in_tdata == BYTE_MIN);
      pin_hi_r <= (in_tdata == BYTE_MAX);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = pin_lo_r ? BYTE_MIN : (pin_hi_r ? BYTE_MAX : rd_data);

  // a request is only taken with a finished table
  a_acc_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> tbl_ready)
    else $error("request accepted before table build finished");

  // table writes never overlap lookups
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sub_wr.we |-> !tbl_ready)
    else $error("table write while lookups enabled");

  // every accepted request shows up as a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("result missing after accepted request");

  // a key write blocks input until the rebuild completes
  a_key_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("input ready right after key write");

endmodule

FILE: sv/kbsd_sub_mem.sv
// kbsd_sub_mem: 256 x 8 substitution memory, one write port, one registered read
// port with read enable; depends on kbsd_pkg
module kbsd_sub_mem (
  input  logic             clk,
  input  kbsd_pkg::sub_wr_t wr,
  input  logic             rd_en,
  input  logic [7:0]       rd_addr,
  output logic [7:0]       rd_data
);
  import kbsd_pkg::*;

  logic [7:0] mem [256];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while rd_en is low, so a stalled result stays put
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/kbsd_table_build.sv
// kbsd_table_build: table build sequencer with its own 256-entry grid memory;
// emits write requests for the substitution memory; depends on kbsd_pkg
module kbsd_table_build (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kbsd_pkg::KeyW-1:0] key,
  output kbsd_pkg::sub_wr_t        sub_wr,
  output logic                     ready
);
  import kbsd_pkg::*;

  build_state_t state_r, state_nxt;

  logic [KeyW-1:0] kb_r;
  logic [3:0]      row_r, col_r;
  logic [3:0]      hx_r, lx_r;
  logic [7:0]      pos_r, cnt_r;
  logic            rd_vld_r;
  logic [8:0]      fill_r;

  logic gen_en, scan_en, init_en;

  logic [7:0] grid [256];
  logic [7:0] grid_q_r;

  logic [7:0] kb [7];
  logic [7:0] mix [16];
  logic [7:0] seed_lo;
  logic [3:0] hi_src, hi_cur, lo_src, lo_cur;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      kb[i] = kb_r[8*i +: 8];
    end
    mix[0]  = kb[1];
    mix[1]  = kb[1] ^ kb[6];
    mix[2]  = kb[2] ^ kb[3];
    mix[3]  = kb[2];
    mix[4]  = kb[2] ^ kb[1];
    mix[5]  = kb[3] ^ kb[4];
    mix[6]  = kb[3];
    mix[7]  = kb[3] ^ kb[2];
    mix[8]  = kb[4] ^ kb[5];
    mix[9]  = kb[4];
    mix[10] = kb[4] ^ kb[3];
    mix[11] = kb[5] ^ kb[6];
    mix[12] = kb[5];
    mix[13] = kb[5] ^ kb[4];
    mix[14] = kb[6] ^ kb[1];
    mix[15] = kb[6];
  end

  // high nibble: generator seeded by kb0, one step per row
  assign hi_src  = (row_r == 4'd0) ? kb[0][7:4] : hx_r;
  assign hi_cur  = lcg_step(hi_src, kb[0]);
  // low nibble: generator seeded by the row's mix byte, one step per column
  assign seed_lo = mix[row_r];
  assign lo_src  = (col_r == 4'd0) ? seed_lo[7:4] : lx_r;
  assign lo_cur  = lcg_step(lo_src, seed_lo);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:  state_nxt = ST_GEN;
      ST_GEN:   if (row_r == 4'hF && col_r == 4'hF) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == 8'hFF) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_DONE;
      default:  state_nxt = ST_INIT;
    endcase
    if (start) state_nxt = ST_INIT;
  end

  // outputs
  always_comb begin
    init_en = 1'b0;
    gen_en  = 1'b0;
    scan_en = 1'b0;
    ready   = 1'b0;
    unique case (state_r)
      ST_INIT:  init_en = 1'b1;
      ST_GEN:   gen_en  = 1'b1;
      ST_SCAN:  scan_en = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  ready   = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_en && !start;
    end
  end

  // counters and generator state
  always_ff @(posedge clk) begin
    if (init_en) begin
      kb_r   <= key - KeyW'(1);
      row_r  <= 4'd0;
      col_r  <= 4'd0;
      pos_r  <= STRIDE;
      cnt_r  <= 8'd0;
      fill_r <= 9'd1;
    end
    if (gen_en) begin
      col_r <= col_r + 4'd1;
      lx_r  <= lo_cur;
      if (col_r == 4'hF) begin
        row_r <= row_r + 4'd1;
        hx_r  <= hi_cur;
      end
    end
    if (scan_en) begin
      pos_r <= pos_r + STRIDE;
      cnt_r <= cnt_r + 8'd1;
    end
    if (rd_vld_r && sub_wr.we) begin
      fill_r <= fill_r + 9'd1;
    end
  end

  // grid memory: filled row by row, then read with the stride
  always_ff @(posedge clk) begin
    if (gen_en) begin
      grid[{row_r, col_r}] <= {hi_cur, lo_cur};
    end
    if (scan_en) begin
      grid_q_r <= grid[pos_r];
    end
  end

  // drop 0x00 and 0xFF, survivors fill entries 1..254
  always_comb begin
    sub_wr.addr = fill_r[7:0];
    sub_wr.data = grid_q_r;
    sub_wr.we   = rd_vld_r && grid_q_r != BYTE_MIN && grid_q_r != BYTE_MAX
                  && fill_r < 9'd255;
  end

endmodule
